// File: rtl/ins_pkg.sv
// Shared types and defaults for the insertion sorter.
`timescale 1ns / 1ps
`default_nettype none

package ins_pkg;

	localparam int CAPACITY_DEF    = 16;
	localparam int VALUE_WIDTH_DEF = 32;

	// Register byte addresses
	localparam logic [2:0] REG_DESCENDING = 3'd0;

	// Controller states, one-hot
	typedef enum logic [1:0] {
		ST_LOAD  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	// Per-cycle command broadcast to every cell
	typedef struct packed {
		logic insert;     // insert the broadcast key this cycle
		logic shift_out;  // move every entry one cell toward the head
		logic descending; // order used by the comparison
	} cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/ins_cell.sv
// One compare-and-shift cell of the sorting chain.
`timescale 1ns / 1ps
`default_nettype none

module ins_cell
	import ins_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  wire                           clk,
	input  wire cell_ctl_t                ctl,
	input  wire logic signed [VALUE_WIDTH-1:0] key,
	input  wire logic signed [VALUE_WIDTH-1:0] left_value,
	input  wire                           left_after,
	input  wire logic signed [VALUE_WIDTH-1:0] right_value,
	input  wire                           right_after,
	input  wire                           occupied,
	output logic signed [VALUE_WIDTH-1:0] value_q,
	output logic                          after
);

	// Flag whether this entry moves right for the new key: an empty cell always does,
	// an occupied one only if it goes after the key and every entry to its right moves
	always_comb begin
		if (!occupied) begin
			after = 1'b1;
		end else if (ctl.descending) begin
			after = (value_q < key) && right_after;
		end else begin
			after = (value_q > key) && right_after;
		end
	end

	// Take the key or the left neighbor on insert, the right neighbor on drain
	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (after) begin
				value_q <= left_after ? left_value : key;
			end
		end else if (ctl.shift_out) begin
			value_q <= right_value;
		end
	end

endmodule

`default_nettype wire

// File: rtl/insertion_sorter.sv
// Top level of the stable insertion sorter: cell chain, controller and register port.
`timescale 1ns / 1ps
`default_nettype none

// Stable insertion sorter. Words arrive on the slave stream and are inserted, one
// word per cycle, into a chain of CAPACITY compare-and-shift cells; every cell
// compares its entry with the broadcast key and moves right in the same cycle, so
// loading runs at one word per clock. The word with tlast set is inserted as well
// and starts the drain: the chain shifts toward cell 0 once per accepted output
// word, giving n result words for a set of n entries, and the slave
// side is stalled during the drain. Equal values keep arrival order. Words that
// arrive while the chain is full are dropped and reported on m_tuser for every
// word of that set. Register descending (address 0, bit 0) selects descending
// order; the user writes it only while the block is idle (not enforced).
module insertion_sorter
	import ins_pkg::*;
#(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// slave stream
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [((VALUE_WIDTH+7)/8)*8-1:0] s_tdata, // value
	input  wire                          s_tlast,     // last_in
	// master stream
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [((VALUE_WIDTH+7)/8)*8-1:0] m_tdata, // sorted_value
	output logic                         m_tlast,     // last_out
	output logic                         m_tuser,     // overflowed
	// configuration
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [2:0]                   paddr,
	input  wire  [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	localparam int TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8;
	localparam int FILL_W  = $clog2(CAPACITY + 1);
	localparam logic [FILL_W-1:0] FULL = FILL_W'(CAPACITY);

	state_t                   state_q;
	logic [FILL_W-1:0]        fill_q;
	logic                     drop_q;
	logic                     descending_q;
	cell_ctl_t                ctl;
	logic                     in_acc;
	logic                     out_acc;
	logic                     full;
	logic signed [VALUE_WIDTH-1:0] key;

	logic signed [VALUE_WIDTH-1:0] cell_value [CAPACITY];
	logic                          cell_after [CAPACITY];
	logic signed [VALUE_WIDTH-1:0] left_value [CAPACITY];
	logic                          left_after [CAPACITY];
	logic signed [VALUE_WIDTH-1:0] right_value [CAPACITY];
	logic                          right_after [CAPACITY];
	logic                          occupied [CAPACITY];

	// Register port: always ready, single register read at address 0, written at 0 to 3
	assign pready = 1'b1;
	always_comb begin
		prdata = 32'd0;
		if (paddr == REG_DESCENDING) begin
			prdata = {31'd0, descending_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			descending_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_DESCENDING[2]) begin
			descending_q <= pwdata[0];
		end
	end

	// Handshakes
	assign full     = (fill_q == FULL);
	assign s_tready = (state_q == ST_LOAD);
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = (state_q == ST_DRAIN);
	assign out_acc  = m_tvalid && m_tready;
	assign key      = $signed(s_tdata[VALUE_WIDTH-1:0]);

	// Broadcast command to the chain
	always_comb begin
		ctl.insert     = in_acc && !full;
		ctl.shift_out  = out_acc;
		ctl.descending = descending_q;
	end

	// Controller: fill count, drop flag, load and drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			fill_q  <= '0;
			drop_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (full) begin
							drop_q <= 1'b1;
						end else begin
							fill_q <= fill_q + 1'b1;
						end
						if (s_tlast) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (out_acc) begin
						fill_q <= fill_q - 1'b1;
						if (fill_q == FILL_W'(1)) begin
							drop_q  <= 1'b0;
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Chain of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign occupied[i] = (FILL_W'(i) < fill_q);
		if (i == 0) begin : g_head
			assign left_value[i] = key;
			assign left_after[i] = 1'b0;
		end else begin : g_body
			assign left_value[i] = cell_value[i-1];
			assign left_after[i] = cell_after[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_value[i] = cell_value[i];
			assign right_after[i] = 1'b1;
		end else begin : g_next
			assign right_value[i] = cell_value[i+1];
			assign right_after[i] = cell_after[i+1];
		end

		ins_cell #(
			.VALUE_WIDTH(VALUE_WIDTH)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.key        (key),
			.left_value (left_value[i]),
			.left_after (left_after[i]),
			.right_value(right_value[i]),
			.right_after(right_after[i]),
			.occupied   (occupied[i]),
			.value_q    (cell_value[i]),
			.after      (cell_after[i])
		);
	end

	// Output word comes from the head cell
	assign m_tdata = TDATA_W'($unsigned(cell_value[0]));
	assign m_tlast = (fill_q == FILL_W'(1));
	assign m_tuser = drop_q;

	// Checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL)
		else $error("fill count beyond capacity");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (fill_q != '0))
		else $error("drain with empty chain");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !full) |=> (fill_q == $past(fill_q) + 1'b1))
		else $error("insert did not advance fill count");

	a_drain_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && m_tlast) |=> (state_q == ST_LOAD && !drop_q && fill_q == '0))
		else $error("set end did not return to load");

endmodule

`default_nettype wire
